// ===== hdl/tlct_pkg.sv =====
// Shared types and constants for the text line/column tracker.
`default_nettype none
package tlct_pkg;

  typedef logic [1:0] kind_t;
  typedef logic [7:0] byte_t;

  localparam kind_t KIND_BYTE  = 2'd0;
  localparam kind_t KIND_FIRST = 2'd1;
  localparam kind_t KIND_EMPTY = 2'd2;
  localparam kind_t KIND_EOF   = 2'd3;

  localparam byte_t CH_NL    = 8'h0A;
  localparam byte_t CH_CR    = 8'h0D;
  localparam byte_t CH_TAB   = 8'h09;
  localparam byte_t CH_SPACE = 8'h20;
  localparam byte_t CH_PRINT_LO = 8'h21;
  localparam byte_t CH_PRINT_HI = 8'h7E;

  localparam int TAB_W = 5;
  typedef logic [TAB_W-1:0] tab_t;
  localparam tab_t TAB_WIDTH_RST = 5'd8;

  typedef logic cfg_idx_t;
  localparam cfg_idx_t CFG_TAB_WIDTH = 1'b0;
  localparam cfg_idx_t CFG_USE_STOPS = 1'b1;

endpackage
`default_nettype wire

// ===== hdl/tlct_rem_unit.sv =====
// Iterative restoring remainder unit, one dividend bit per cycle.
`default_nettype none
module tlct_rem_unit #(
  parameter int DIVIDEND_W = 17,
  parameter int DIVISOR_W  = 5
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [DIVIDEND_W-1:0] dividend,
  input  wire logic [DIVISOR_W-1:0]  divisor,
  output logic                       done,
  output logic [DIVISOR_W-1:0]       remainder
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic [DIVIDEND_W-1:0] quo_r, quo_nxt;
  logic [DIVISOR_W-1:0]  rem_r, rem_nxt;
  logic [DIVISOR_W-1:0]  div_r, div_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [DIVISOR_W:0]    trial;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, quo_r[DIVIDEND_W-1]};
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      div_nxt  = divisor;
      cnt_nxt  = CNT_W'(DIVIDEND_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt = {quo_r[DIVIDEND_W-2:0], 1'b0};
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = DIVISOR_W'(trial - {1'b0, div_r});
      end else begin
        rem_nxt = trial[DIVISOR_W-1:0];
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule
`default_nettype wire

// ===== hdl/text_line_column_tracker.sv =====
// Top level: line and column tracker for a tokenized text byte stream.
//
// Input stream: in_tdata carries one text byte, in_tuser its kind (byte
// inside a token, first byte of a token, empty token, end of file).
// Token starts, empty tokens and end of file each produce one request on
// the output stream: the line/column reached before that byte, with
// out_tlast high for the end-of-file position. Plain token bytes produce
// nothing.
// Most bytes are done as soon as they are accepted. A tab in tab-stop mode with a
// width above 1 holds the input: the stop is found by a remainder unit that
// retires one bit of column + width + 1 per cycle, during which in_tready
// is low.
// A result is in the output register in the cycle after its byte; no byte
// is accepted while it waits for out_tready. The cfg channel is always
// ready and should be written only while idle. Reset (rst_n low,
// synchronous) sets line and column to 1, clears pending UTF-8 skips, and
// loads tab width 8 with tab stops on.
// End of file returns line and column to 1; the registers are kept.
`default_nettype none
module text_line_column_tracker
  import tlct_pkg::*;
#(
  parameter int LINE_BITS   = 24,
  parameter int COLUMN_BITS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // cfg
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic                   cfg_index,
  input  wire logic [TAB_W-1:0]       cfg_data,
  // input stream
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [7:0]             in_tdata,   // [7:0] byte_value
  input  wire logic [1:0]             in_tuser,   // [1:0] kind
  // output stream
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [((LINE_BITS+COLUMN_BITS+7)/8)*8-1:0] out_tdata,
                                      // line_number, then column_number, zero pad
  output logic                        out_tlast   // is_final
);

  localparam int DIVD_W = COLUMN_BITS + 1;
  localparam int OUT_W  = ((LINE_BITS + COLUMN_BITS + 7) / 8) * 8;
  localparam logic [LINE_BITS-1:0]   LINE_MAX = {LINE_BITS{1'b1}};
  localparam logic [COLUMN_BITS-1:0] COL_MAX  = {COLUMN_BITS{1'b1}};
  localparam logic [LINE_BITS-1:0]   LINE_ONE = LINE_BITS'(1);
  localparam logic [COLUMN_BITS-1:0] COL_ONE  = COLUMN_BITS'(1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DIV  = 1'b1;

  logic                   state_r, state_nxt;
  logic [LINE_BITS-1:0]   line_r, line_nxt;
  logic [COLUMN_BITS-1:0] col_r, col_nxt;
  logic [1:0]             skip_r, skip_nxt;
  tab_t                   tab_width_r;
  logic                   use_stops_r;
  logic [DIVD_W-1:0]      tab_sum_r, tab_sum_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [LINE_BITS-1:0]   out_line_r;
  logic [COLUMN_BITS-1:0] out_col_r;
  logic                   out_last_r;

  logic                   in_acc;
  kind_t                  kind;
  byte_t                  b;
  logic [1:0]             skip_eff;
  logic [DIVD_W-1:0]      col_ext, sum_one, sum_tab, stop_col;
  logic [COLUMN_BITS-1:0] col_plus1, col_plus_tab, col_stop;
  logic                   div_start, div_done;
  tab_t                   div_rem;

  assign kind      = kind_t'(in_tuser);
  assign b         = in_tdata;
  assign in_tready = (state_r == ST_IDLE) && (!out_valid_r || out_tready);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign col_ext      = {1'b0, col_r};
  assign sum_one      = col_ext + DIVD_W'(1);
  assign sum_tab      = col_ext + DIVD_W'(tab_width_r);
  assign col_plus1    = sum_one[COLUMN_BITS] ? COL_MAX : sum_one[COLUMN_BITS-1:0];
  assign col_plus_tab = sum_tab[COLUMN_BITS] ? COL_MAX : sum_tab[COLUMN_BITS-1:0];
  assign stop_col     = tab_sum_r - DIVD_W'(div_rem);
  assign col_stop     = stop_col[COLUMN_BITS] ? COL_MAX : stop_col[COLUMN_BITS-1:0];

  always_comb begin
    state_nxt   = state_r;
    line_nxt    = line_r;
    col_nxt     = col_r;
    skip_nxt    = skip_r;
    tab_sum_nxt = tab_sum_r;
    div_start   = 1'b0;
    skip_eff    = (kind == KIND_FIRST) ? 2'd0 : skip_r;
    if (state_r == ST_DIV) begin
      if (div_done) begin
        col_nxt   = col_stop;
        state_nxt = ST_IDLE;
      end
    end else if (in_acc) begin
      if (kind == KIND_EMPTY) begin
        skip_nxt = 2'd0;
      end else if (kind == KIND_EOF) begin
        skip_nxt = 2'd0;
        line_nxt = LINE_ONE;
        col_nxt  = COL_ONE;
      end else if (skip_eff != 2'd0) begin
        skip_nxt = skip_eff - 2'd1;
      end else begin
        skip_nxt = 2'd0;
        if (b == CH_NL) begin
          col_nxt = COL_ONE;
          if (line_r != LINE_MAX) begin
            line_nxt = line_r + LINE_ONE;
          end
        end else if (b == CH_CR) begin
          col_nxt = col_r;
        end else if (b == CH_TAB) begin
          if (use_stops_r && (tab_width_r > tab_t'(1))) begin
            tab_sum_nxt = sum_tab + DIVD_W'(1);
            div_start   = 1'b1;
            state_nxt   = ST_DIV;
          end else begin
            col_nxt = col_plus_tab;
          end
        end else if (b == CH_SPACE) begin
          col_nxt = col_plus1;
        end else if (b[7:3] == 5'b11110) begin
          col_nxt  = col_plus1;
          skip_nxt = 2'd3;
        end else if (b[7:4] == 4'b1110) begin
          col_nxt  = col_plus1;
          skip_nxt = 2'd2;
        end else if (b[7:5] == 3'b110) begin
          col_nxt  = col_plus1;
          skip_nxt = 2'd1;
        end else if (b >= CH_PRINT_LO && b <= CH_PRINT_HI) begin
          col_nxt = col_plus1;
        end
      end
    end
  end

  assign out_valid_nxt = (in_acc && (kind != KIND_BYTE)) ? 1'b1 :
                         (out_tready ? 1'b0 : out_valid_r);

  tlct_rem_unit #(
    .DIVIDEND_W (DIVD_W),
    .DIVISOR_W  (TAB_W)
  ) u_rem (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (tab_sum_nxt),
    .divisor   (tab_width_r),
    .done      (div_done),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      line_r      <= LINE_ONE;
      col_r       <= COL_ONE;
      skip_r      <= 2'd0;
      tab_width_r <= TAB_WIDTH_RST;
      use_stops_r <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      line_r      <= line_nxt;
      col_r       <= col_nxt;
      skip_r      <= skip_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_TAB_WIDTH) begin
          tab_width_r <= cfg_data;
        end else begin
          use_stops_r <= cfg_data[0];
        end
      end
    end
    tab_sum_r <= tab_sum_nxt;
    if (in_acc && (kind != KIND_BYTE)) begin
      out_line_r <= line_r;
      out_col_r  <= col_r;
      out_last_r <= (kind == KIND_EOF);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({out_col_r, out_line_r});
  assign out_tlast  = out_last_r;

  a_pos_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (line_r != '0) && (col_r != '0))
    else $error("line or column reached zero");

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV))
    else $error("remainder done outside tab-stop step");

  a_eof_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (kind == KIND_EOF)) |=> (line_r == LINE_ONE) && (col_r == COL_ONE)
      && (skip_r == 2'd0))
    else $error("end of file did not restart position");

endmodule
`default_nettype wire

// ===== bench/tlct_position_checker.sv =====
`timescale 1ns / 1ps
// Position checker: predicts the line and column stream and compares it with the tracker output.
module tlct_position_checker
  import tlct_pkg::*;
#(
  parameter int LINE_BITS   = 24,
  parameter int COLUMN_BITS = 16,
  parameter int OUT_W       = ((LINE_BITS+COLUMN_BITS+7)/8)*8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  cfg_idx_t         cfg_index,
  input  tab_t             cfg_data,
  input  logic             in_tvalid,
  input  logic             in_tready,
  input  byte_t            in_tdata,
  input  kind_t            in_tuser,
  input  logic             out_tvalid,
  input  logic             out_tready,
  input  logic [OUT_W-1:0] out_tdata,
  input  logic             out_tlast,
  output int               mismatches,
  output int               pending
);

  localparam logic [LINE_BITS-1:0]   LINE_TOP = '1;
  localparam logic [COLUMN_BITS-1:0] COL_TOP  = '1;

  typedef struct packed {
    logic [LINE_BITS-1:0]   line;
    logic [COLUMN_BITS-1:0] col;
    logic                   last;
  } position_t;

  position_t                expected_pos_q[$];
  logic [LINE_BITS-1:0]     cur_line;
  logic [COLUMN_BITS-1:0]   cur_col;
  logic [1:0]               skip_cnt;
  tab_t                     tab_w;
  logic                     tab_stops;

  function automatic void bump_column(input longint unsigned n);
    longint unsigned c;
    c = longint'(cur_col) + n;
    cur_col = (c > COL_TOP) ? COL_TOP : c[COLUMN_BITS-1:0];
  endfunction

  function automatic void consume_byte(input byte_t b);
    longint unsigned c;
    if (skip_cnt != 2'd0) begin
      skip_cnt = skip_cnt - 2'd1;
    end else if (b == CH_NL) begin
      cur_col = 1;
      if (cur_line != LINE_TOP) cur_line = cur_line + 1'b1;
    end else if (b == CH_CR) begin
    end else if (b == CH_TAB) begin
      if (tab_stops && tab_w > 1) begin
        c = longint'(cur_col) + longint'(tab_w) + 1;
        c = (c / tab_w) * tab_w;
        cur_col = (c > COL_TOP) ? COL_TOP : c[COLUMN_BITS-1:0];
      end else begin
        bump_column(tab_w);
      end
    end else if (b == CH_SPACE) begin
      bump_column(1);
    end else begin
      casez (b)
        8'b11110???: begin
          bump_column(1);
          skip_cnt = 2'd3;
        end
        8'b1110????: begin
          bump_column(1);
          skip_cnt = 2'd2;
        end
        8'b110?????: begin
          bump_column(1);
          skip_cnt = 2'd1;
        end
        default: begin
          if (b >= CH_PRINT_LO && b <= CH_PRINT_HI) bump_column(1);
        end
      endcase
    end
  endfunction

  initial begin
    mismatches = 0;
    pending = 0;
  end

  always @(posedge clk) begin : track
    position_t want;
    position_t got;
    if (!rst_n) begin
      cur_line  = 1;
      cur_col   = 1;
      skip_cnt  = 2'd0;
      tab_w     = TAB_WIDTH_RST;
      tab_stops = 1'b1;
      expected_pos_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_TAB_WIDTH: tab_w = cfg_data;
          CFG_USE_STOPS: tab_stops = cfg_data[0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got.line = out_tdata[LINE_BITS-1:0];
        got.col  = out_tdata[LINE_BITS+COLUMN_BITS-1:LINE_BITS];
        got.last = out_tlast;
        if (expected_pos_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected request, expected none, got line %0d col %0d last %0b",
                   $time, got.line, got.col, got.last);
        end else begin
          want = expected_pos_q.pop_front();
          if (got.line !== want.line) begin
            mismatches++;
            $display("%0t: line expected %0d got %0d", $time, want.line, got.line);
          end
          if (got.col !== want.col) begin
            mismatches++;
            $display("%0t: column expected %0d got %0d", $time, want.col, got.col);
          end
          if (got.last !== want.last) begin
            mismatches++;
            $display("%0t: tlast expected %0b got %0b", $time, want.last, got.last);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser == KIND_BYTE) begin
          consume_byte(in_tdata);
        end else begin
          skip_cnt = 2'd0;
          want.line = cur_line;
          want.col  = cur_col;
          want.last = (in_tuser == KIND_EOF);
          expected_pos_q.push_back(want);
          if (in_tuser == KIND_FIRST) begin
            consume_byte(in_tdata);
          end else if (in_tuser == KIND_EOF) begin
            cur_line = 1;
            cur_col  = 1;
          end
        end
      end
    end
    pending = expected_pos_q.size();
  end

endmodule

// ===== bench/tb_text_line_column_tracker.sv =====
`timescale 1ns / 1ps
// Testbench top: clock, reset, stimulus, flow control and verdict for the line/column tracker.
module tb_text_line_column_tracker;
  import tlct_pkg::*;

  localparam int LINE_BITS       = 24;
  localparam int COLUMN_BITS     = 16;
  localparam int OUT_W           = ((LINE_BITS+COLUMN_BITS+7)/8)*8;
  localparam int STALL_LIMIT     = 2000;
  localparam int DRAIN_CYCLES    = 40;
  localparam int HOLD_OFF_CYCLES = 150;
  localparam int TAB_RUN         = 40;

  logic             clk;
  logic             rst_n;
  logic             cfg_valid;
  logic             cfg_ready;
  cfg_idx_t         cfg_index;
  tab_t             cfg_data;
  logic             in_tvalid;
  logic             in_tready;
  byte_t            in_tdata;
  kind_t            in_tuser;
  logic             out_tvalid;
  logic             out_tready;
  logic [OUT_W-1:0] out_tdata;
  logic             out_tlast;

  int   mismatches;
  int   pending;
  int   items_sent;
  int   idle_cycles;
  logic no_gaps;
  logic hold_off_req;

  text_line_column_tracker #(
    .LINE_BITS  (LINE_BITS),
    .COLUMN_BITS(COLUMN_BITS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  tlct_position_checker #(
    .LINE_BITS  (LINE_BITS),
    .COLUMN_BITS(COLUMN_BITS)
  ) u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .mismatches(mismatches),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin : receiver
    int hold;
    out_tready = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold = HOLD_OFF_CYCLES;
      end else begin
        hold = no_gaps ? 0 : $urandom_range(0, 6);
      end
      if (hold != 0) begin
        out_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  function automatic byte_t pick_text_byte();
    byte_t b;
    case ($urandom_range(0, 11))
      0:       b = CH_NL;
      1:       b = CH_TAB;
      2:       b = CH_SPACE;
      3:       b = CH_CR;
      4, 5, 6: b = byte_t'($urandom_range(CH_PRINT_LO, CH_PRINT_HI));
      7:       b = {3'b110, 5'($urandom)};
      8:       b = {4'b1110, 4'($urandom)};
      9:       b = {5'b11110, 3'($urandom)};
      10:      b = {2'b10, 6'($urandom)};
      default: b = byte_t'($urandom);
    endcase
    return b;
  endfunction

  task automatic send(input kind_t k, input byte_t b);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= k;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  // one character, with its UTF-8 continuation bytes (sometimes cut short or corrupted)
  task automatic send_char(input kind_t k);
    byte_t b;
    int    follow;
    b = pick_text_byte();
    casez (b)
      8'b11110???: follow = 3;
      8'b1110????: follow = 2;
      8'b110?????: follow = 1;
      default:     follow = 0;
    endcase
    if (follow != 0 && $urandom_range(0, 7) == 0) follow = $urandom_range(0, follow - 1);
    send(k, b);
    repeat (follow) begin
      if ($urandom_range(0, 9) == 0) send(KIND_BYTE, pick_text_byte());
      else send(KIND_BYTE, {2'b10, 6'($urandom)});
    end
  endtask

  task automatic run_text(input int count);
    int stop_at;
    int len;
    int r;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        send(kind_t'($urandom), byte_t'($urandom));
      end else if (r < 13) begin
        send(KIND_EMPTY, byte_t'($urandom));
      end else if (r < 16) begin
        send(KIND_EOF, byte_t'($urandom));
      end else begin
        len = $urandom_range(0, 5);
        send_char(KIND_FIRST);
        repeat (len) send_char(KIND_BYTE);
      end
    end
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input tab_t val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_tabs(input tab_t width, input logic stops);
    write_reg(CFG_TAB_WIDTH, width);
    write_reg(CFG_USE_STOPS, tab_t'(stops));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin : stimulus
    tab_t width_plan[6];
    logic stops_plan[6];
    rst_n        = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = CFG_TAB_WIDTH;
    cfg_data     = '0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = KIND_BYTE;
    items_sent   = 0;
    idle_cycles  = 0;
    no_gaps      = 1'b0;
    hold_off_req = 1'b0;
    width_plan = '{5'd1, 5'd16, 5'd3, 5'd16, 5'd1, 5'd8};
    stops_plan = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset register values
    send(KIND_EMPTY, 8'hFF);
    send(KIND_FIRST, "A");
    send(KIND_BYTE, CH_SPACE);
    send(KIND_BYTE, CH_TAB);
    send(KIND_BYTE, CH_CR);
    send(KIND_BYTE, 8'h00);
    send(KIND_BYTE, 8'h7F);
    send(KIND_BYTE, 8'hFF);
    send(KIND_BYTE, 8'h80);
    send(KIND_FIRST, 8'hC3);
    send(KIND_BYTE, 8'hA9);
    send(KIND_FIRST, 8'hE2);
    send(KIND_BYTE, 8'h82);
    send(KIND_BYTE, 8'hAC);
    send(KIND_BYTE, 8'hF7);
    send(KIND_BYTE, 8'h9F);
    send(KIND_EMPTY, 8'h00);   // pending skip dropped at the token edge
    send(KIND_BYTE, CH_PRINT_HI);
    send(KIND_BYTE, CH_NL);
    send(KIND_FIRST, CH_PRINT_LO);
    send(KIND_BYTE, 8'hF8);
    send(KIND_EOF, 8'h00);
    send(KIND_FIRST, CH_NL);
    send(KIND_EOF, 8'hFF);
    send(KIND_EMPTY, 8'h00);
    settle();

    // long run of fixed-width tabs, then tab stops from a wide column
    set_tabs(5'd16, 1'b0);
    no_gaps = 1'b1;
    send(KIND_FIRST, CH_TAB);
    repeat (TAB_RUN) send(KIND_BYTE, CH_TAB);
    send(KIND_EMPTY, 8'h00);
    no_gaps = 1'b0;
    settle();
    set_tabs(5'd16, 1'b1);
    send(KIND_FIRST, CH_TAB);
    send(KIND_BYTE, "a");
    send(KIND_BYTE, CH_SPACE);
    send(KIND_EMPTY, 8'h00);
    send(KIND_BYTE, CH_NL);
    send(KIND_EMPTY, 8'h00);
    send(KIND_EOF, 8'h00);
    settle();

    for (int p = 0; p < 6; p++) begin
      if (p == 5) begin
        width_plan[p] = tab_t'($urandom_range(1, 16));
        stops_plan[p] = 1'($urandom);
      end
      set_tabs(width_plan[p], stops_plan[p]);
      no_gaps = (p % 3 == 2);
      if (p == 1) hold_off_req = 1'b1;
      run_text(55);
      settle();
    end

    if (mismatches == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/tlct_pkg.sv
hdl/tlct_rem_unit.sv
hdl/text_line_column_tracker.sv
bench/tlct_position_checker.sv
bench/tb_text_line_column_tracker.sv
